/* rtl/sw_tmr_pkg.sv */
// Shared types, constants and command codes for the software timer table.
// Used by sw_tmr_cell and software_timer_table; depends on nothing else.
package sw_tmr_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int COUNT_BITS = 16;

    typedef logic [COUNT_BITS-1:0] t_count;

    // Command codes carried on the input func field.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_CREATE  = 2'd1;
    localparam logic [1:0] FUNC_DELETE  = 2'd2;
    localparam logic [1:0] FUNC_SERVICE = 2'd3;

    // Operations broadcast from the controller to every cell.
    localparam logic [2:0] CO_NONE   = 3'd0;
    localparam logic [2:0] CO_TICK   = 3'd1;
    localparam logic [2:0] CO_LOAD   = 3'd2;
    localparam logic [2:0] CO_DELETE = 3'd3;
    localparam logic [2:0] CO_FIRE   = 3'd4;
    localparam logic [2:0] CO_CLEAR  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       use_free;
        logic [7:0] key;
        t_count     period;
        logic       periodic;
        logic       action;
    } t_cell_cmd;

    // Priority tokens handed from one cell to the next: a token that is
    // still set means no earlier cell claimed that search.
    typedef struct packed {
        logic match;
        logic free;
        logic svc;
    } t_tok;

    typedef struct packed {
        logic match_hit;
        logic free_hit;
        logic svc_hit;
        logic svc_want;
    } t_cell_stat;

    // The input period is 16 bits wide; the count keeps COUNT_BITS of it.
    function automatic t_count fit_count(input logic [15:0] value);
        logic [47:0] wide;
        wide = {32'd0, value};
        return wide[COUNT_BITS-1:0];
    endfunction

endpackage

/* rtl/sw_tmr_cell.sv */
// One timer slot of the software timer table and its link in the priority chain.
// Depends on sw_tmr_pkg.
module sw_tmr_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sw_tmr_pkg::t_cell_cmd  i_cmd,
    input  sw_tmr_pkg::t_tok       i_tok,
    output sw_tmr_pkg::t_tok       o_tok,
    output sw_tmr_pkg::t_cell_stat o_stat
);
    import sw_tmr_pkg::*;

    logic       r_en;
    logic       r_done;
    logic [7:0] r_key;
    t_count     r_rem;
    t_count     r_rel;
    logic       r_per;
    logic       r_act;

    logic want_match;
    logic want_free;
    logic want_svc;
    logic load_sel;

    assign want_match = r_en && (r_key == i_cmd.key);
    assign want_free  = !r_en;
    assign want_svc   = r_en && (r_rem == '0) && r_act && !r_done;

    assign o_tok.match = i_tok.match && !want_match;
    assign o_tok.free  = i_tok.free && !want_free;
    assign o_tok.svc   = i_tok.svc && !want_svc;

    assign o_stat.match_hit = i_tok.match && want_match;
    assign o_stat.free_hit  = i_tok.free && want_free;
    assign o_stat.svc_hit   = i_tok.svc && want_svc;
    assign o_stat.svc_want  = want_svc;

    assign load_sel = i_cmd.use_free ? o_stat.free_hit : o_stat.match_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                CO_LOAD: begin
                    if (load_sel) begin
                        r_en <= 1'b1;
                    end
                end
                CO_DELETE: begin
                    if (o_stat.match_hit) begin
                        r_en <= 1'b0;
                    end
                end
                CO_FIRE: begin
                    if (o_stat.svc_hit) begin
                        r_done <= 1'b1;
                        if (!r_per) begin
                            r_en <= 1'b0;
                        end
                    end
                end
                CO_CLEAR: begin
                    r_done <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CO_TICK: begin
                if (r_en && (r_rem != '0)) begin
                    r_rem <= r_rem - t_count'(1);
                end
            end
            CO_LOAD: begin
                if (load_sel) begin
                    r_key <= i_cmd.key;
                    r_rem <= i_cmd.period;
                    r_rel <= i_cmd.period;
                    r_per <= i_cmd.periodic;
                    r_act <= i_cmd.action;
                end
            end
            CO_FIRE: begin
                if (o_stat.svc_hit && r_per) begin
                    r_rem <= r_rel;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/software_timer_table.sv */
// Top level of the software timer table: command controller, result register
// and the chain of sw_tmr_cell slots. Depends on sw_tmr_pkg and sw_tmr_cell.
//
// Channel   Direction  Handshake            Beat contents
// command   in         i_valid / o_stall    i_func, i_key, i_period, i_periodic, i_has_action
// result    out        o_valid / i_stall    o_slot, o_status, o_fired, o_last
//
// A command beat is taken only while the controller is idle; the work state then
// does the work and loads the result register once it is free; tick, create and delete give one beat.
// Service gives one result beat per cycle, unless stalled, for each expired slot with an action.
// A stalled result holds the controller in its work state with the slots frozen.
// Reset is synchronous and active low and clears every slot's enable flag.
module software_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_key,
    input  logic [15:0] i_period,
    input  logic        i_periodic,
    input  logic        i_has_action,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_slot,
    output logic        o_status,
    output logic        o_fired,
    output logic        o_last
);
    import sw_tmr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic r_state;
    logic n_state;

    // Command held for the duration of its work.
    logic [1:0] r_func;
    logic [7:0] r_key;
    t_count     r_period;
    logic       r_periodic;
    logic       r_action;

    // Result register.
    logic       r_ov;
    logic       n_ov;
    logic [2:0] r_slot;
    logic [2:0] n_slot;
    logic       r_status;
    logic       n_status;
    logic       r_fired;
    logic       n_fired;
    logic       r_last;
    logic       n_last;

    logic       in_take;
    logic       out_free;
    logic       emit;
    t_cell_cmd  cmd;

    t_tok                 tok [NUM_SLOTS+1];
    t_cell_stat           stat [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] match_hit;
    logic [NUM_SLOTS-1:0] free_hit;
    logic [NUM_SLOTS-1:0] svc_hit;
    logic [NUM_SLOTS-1:0] svc_want;
    logic [2:0]           match_idx;
    logic [2:0]           free_idx;
    logic [2:0]           svc_idx;
    logic                 svc_only;

    // The slot number reported keeps the low three bits of the index.
    function automatic logic [2:0] enc_slot(input logic [NUM_SLOTS-1:0] onehot);
        logic [31:0] idx;
        idx = 32'd0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (onehot[j]) begin
                idx = idx | 32'(j);
            end
        end
        return idx[2:0];
    endfunction

    assign o_stall  = (r_state != ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    // Every search enters the chain at slot zero with its token set.
    assign tok[0] = '{match: 1'b1, free: 1'b1, svc: 1'b1};

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        sw_tmr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_stat  (stat[g])
        );
        assign match_hit[g] = stat[g].match_hit;
        assign free_hit[g]  = stat[g].free_hit;
        assign svc_hit[g]   = stat[g].svc_hit;
        assign svc_want[g]  = stat[g].svc_want;
    end

    assign match_idx = enc_slot(match_hit);
    assign free_idx  = enc_slot(free_hit);
    assign svc_idx   = enc_slot(svc_hit);
    // The slot firing now is the last one when no other slot is waiting.
    assign svc_only  = ((svc_want & ~svc_hit) == '0);

    assign emit = (r_state == ST_WORK) && out_free;

    always_comb begin
        cmd.op       = CO_NONE;
        cmd.use_free = 1'b0;
        cmd.key      = r_key;
        cmd.period   = r_period;
        cmd.periodic = r_periodic;
        cmd.action   = r_action;
        n_state      = r_state;
        n_ov         = r_ov && i_stall;
        n_slot       = r_slot;
        n_status     = r_status;
        n_fired      = r_fired;
        n_last       = r_last;

        if (in_take) begin
            n_state = ST_WORK;
            // A service starts with every slot eligible to fire once.
            if (i_func == FUNC_SERVICE) begin
                cmd.op = CO_CLEAR;
            end
        end else if (emit) begin
            n_ov     = 1'b1;
            n_slot   = 3'd0;
            n_status = 1'b0;
            n_fired  = 1'b0;
            n_last   = 1'b1;
            n_state  = ST_IDLE;
            unique case (r_func)
                FUNC_TICK: begin
                    cmd.op = CO_TICK;
                end
                FUNC_CREATE: begin
                    if (|match_hit) begin
                        cmd.op = CO_LOAD;
                        n_slot = match_idx;
                    end else if (|free_hit) begin
                        cmd.op       = CO_LOAD;
                        cmd.use_free = 1'b1;
                        n_slot       = free_idx;
                    end else begin
                        n_status = 1'b1;
                    end
                end
                FUNC_DELETE: begin
                    if (|match_hit) begin
                        cmd.op = CO_DELETE;
                        n_slot = match_idx;
                    end else begin
                        n_status = 1'b1;
                    end
                end
                FUNC_SERVICE: begin
                    if (|svc_hit) begin
                        cmd.op  = CO_FIRE;
                        n_slot  = svc_idx;
                        n_fired = 1'b1;
                        n_last  = svc_only;
                        if (!svc_only) begin
                            n_state = ST_WORK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_status <= n_status;
        r_fired  <= n_fired;
        r_last   <= n_last;
        if (in_take) begin
            r_func     <= i_func;
            r_key      <= i_key;
            r_period   <= fit_count(i_period);
            r_periodic <= i_periodic;
            r_action   <= i_has_action;
        end
    end

    assign o_valid  = r_ov;
    assign o_slot   = r_slot;
    assign o_status = r_status;
    assign o_fired  = r_fired;
    assign o_last   = r_last;

    // A matching key is held by at most one enabled slot.
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK) |-> $onehot0(match_hit))
        else $error("more than one slot claims the key");

    a_svc_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(svc_hit))
        else $error("more than one slot fires in one cycle");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fired) |-> !o_status)
        else $error("fired result carries an error status");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (o_stall && !$stable(r_state)))
        else $error("command taken without entering work state");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_last) |=> (r_state == ST_IDLE))
        else $error("controller busy after the final result");

endmodule
